[rtl/fpvt_pkg.sv]
package fpvt_pkg;

  localparam int NUM_REGS = 6;
  localparam int WORD_W = 32;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_COEF_PAIR_A = 3'd0;
  localparam cfg_idx_t REG_COEF_PAIR_B = 3'd1;
  localparam cfg_idx_t REG_COEF_PAIR_C = 3'd2;
  localparam cfg_idx_t REG_COEF_PAIR_D = 3'd3;
  localparam cfg_idx_t REG_COEF_LAST_SHIFT_X = 3'd4;
  localparam cfg_idx_t REG_SHIFT_Y_Z = 3'd5;

  localparam logic [CFG_W-1:0] COEF_PAIR_A_RST = 64'd65536;
  localparam logic [CFG_W-1:0] COEF_PAIR_B_RST = 64'd0;
  localparam logic [CFG_W-1:0] COEF_PAIR_C_RST = 64'd65536;
  localparam logic [CFG_W-1:0] COEF_PAIR_D_RST = 64'd0;
  localparam logic [CFG_W-1:0] COEF_LAST_SHIFT_X_RST = 64'd65536;
  localparam logic [CFG_W-1:0] SHIFT_Y_Z_RST = 64'd0;

  // Cycles from an accepted request to its result strobe.
  localparam int LATENCY = 4;

  typedef struct packed {
    logic signed [WORD_W-1:0] in_x;
    logic signed [WORD_W-1:0] in_y;
    logic signed [WORD_W-1:0] in_z;
    logic                     final_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] out_x;
    logic signed [WORD_W-1:0] out_y;
    logic signed [WORD_W-1:0] out_z;
    logic                     overflow;
    logic                     final_result;
  } result_t;

endpackage

[rtl/fixed_point_vertex_transform_unit.sv]
// Channel   Handshake        Payload    Notes
// vertex    start / busy     vertex     accepted when start is high and busy is low
// result    done             result     valid for one cycle, cannot be held off
// config    cfg_we           cfg_data   register cfg_index, written at once
//
// A request is accepted in every cycle outside reset, and its result appears on done once it has passed the stages.
// The four stages are the input register, the multipliers, the pair adders and
// the final adder with its overflow check.
// Synchronous reset clears the pipeline valid bits and sets the identity transform.
// Busy is high only during reset, and the receiver cannot stall the pipeline.
module fixed_point_vertex_transform_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  fpvt_pkg::vertex_t           vertex,
  output logic                        done,
  output fpvt_pkg::result_t           result,
  input  logic                        cfg_we,
  input  fpvt_pkg::cfg_idx_t          cfg_index,
  input  logic [fpvt_pkg::CFG_W-1:0]  cfg_data
);

  localparam int W = fpvt_pkg::WORD_W;
  localparam int LAT = fpvt_pkg::LATENCY;

  logic [fpvt_pkg::CFG_W-1:0] coef_a;
  logic [fpvt_pkg::CFG_W-1:0] coef_b;
  logic [fpvt_pkg::CFG_W-1:0] coef_c;
  logic [fpvt_pkg::CFG_W-1:0] coef_d;
  logic [fpvt_pkg::CFG_W-1:0] coef_e;
  logic [fpvt_pkg::CFG_W-1:0] shift_yz;

  logic [LAT-1:0] valid;
  logic [LAT-1:0] last;
  logic signed [W-1:0] vx;
  logic signed [W-1:0] vy;
  logic signed [W-1:0] vz;
  logic signed [W-1:0] res_x;
  logic signed [W-1:0] res_y;
  logic signed [W-1:0] res_z;
  logic ovf_x;
  logic ovf_y;
  logic ovf_z;
  logic accept;

  assign busy = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= fpvt_pkg::COEF_PAIR_A_RST;
      coef_b <= fpvt_pkg::COEF_PAIR_B_RST;
      coef_c <= fpvt_pkg::COEF_PAIR_C_RST;
      coef_d <= fpvt_pkg::COEF_PAIR_D_RST;
      coef_e <= fpvt_pkg::COEF_LAST_SHIFT_X_RST;
      shift_yz <= fpvt_pkg::SHIFT_Y_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fpvt_pkg::REG_COEF_PAIR_A: coef_a <= cfg_data;
        fpvt_pkg::REG_COEF_PAIR_B: coef_b <= cfg_data;
        fpvt_pkg::REG_COEF_PAIR_C: coef_c <= cfg_data;
        fpvt_pkg::REG_COEF_PAIR_D: coef_d <= cfg_data;
        fpvt_pkg::REG_COEF_LAST_SHIFT_X: coef_e <= cfg_data;
        fpvt_pkg::REG_SHIFT_Y_Z: shift_yz <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    last <= {last[LAT-2:0], vertex.final_vertex};
    vx <= vertex.in_x;
    vy <= vertex.in_y;
    vz <= vertex.in_z;
  end

  fpvt_row #(.FRAC_BITS(FRAC_BITS)) u_row_x (
    .clk(clk), .x(vx), .y(vy), .z(vz),
    .coef_x(coef_a[W-1:0]), .coef_y(coef_b[2*W-1:W]), .coef_z(coef_d[W-1:0]),
    .offset(coef_e[2*W-1:W]), .res(res_x), .ovf(ovf_x)
  );

  fpvt_row #(.FRAC_BITS(FRAC_BITS)) u_row_y (
    .clk(clk), .x(vx), .y(vy), .z(vz),
    .coef_x(coef_a[2*W-1:W]), .coef_y(coef_c[W-1:0]), .coef_z(coef_d[2*W-1:W]),
    .offset(shift_yz[W-1:0]), .res(res_y), .ovf(ovf_y)
  );

  fpvt_row #(.FRAC_BITS(FRAC_BITS)) u_row_z (
    .clk(clk), .x(vx), .y(vy), .z(vz),
    .coef_x(coef_b[W-1:0]), .coef_y(coef_c[2*W-1:W]), .coef_z(coef_e[W-1:0]),
    .offset(shift_yz[2*W-1:W]), .res(res_z), .ovf(ovf_z)
  );

  assign done = valid[LAT-1];
  assign result.out_x = res_x;
  assign result.out_y = res_y;
  assign result.out_z = res_z;
  assign result.overflow = ovf_x | ovf_y | ovf_z;
  assign result.final_result = last[LAT-1];

endmodule

[rtl/fpvt_row.sv]
module fpvt_row #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic signed [fpvt_pkg::WORD_W-1:0]   x,
  input  logic signed [fpvt_pkg::WORD_W-1:0]   y,
  input  logic signed [fpvt_pkg::WORD_W-1:0]   z,
  input  logic signed [fpvt_pkg::WORD_W-1:0]   coef_x,
  input  logic signed [fpvt_pkg::WORD_W-1:0]   coef_y,
  input  logic signed [fpvt_pkg::WORD_W-1:0]   coef_z,
  input  logic signed [fpvt_pkg::WORD_W-1:0]   offset,
  output logic signed [fpvt_pkg::WORD_W-1:0]   res,
  output logic                                 ovf
);

  localparam int W = fpvt_pkg::WORD_W;

  logic signed [2*W-1:0] full_x;
  logic signed [2*W-1:0] full_y;
  logic signed [2*W-1:0] full_z;
  logic signed [W-1:0]   prod_x;
  logic signed [W-1:0]   prod_y;
  logic signed [W-1:0]   prod_z;
  logic signed [W:0]     pair_xy;
  logic signed [W:0]     pair_zo;
  logic signed [W+1:0]   sum;

  assign full_x = x * coef_x;
  assign full_y = y * coef_y;
  assign full_z = z * coef_z;
  assign sum = (W+2)'(pair_xy) + (W+2)'(pair_zo);

  always_ff @(posedge clk) begin
    prod_x <= full_x[FRAC_BITS+W-1:FRAC_BITS];
    prod_y <= full_y[FRAC_BITS+W-1:FRAC_BITS];
    prod_z <= full_z[FRAC_BITS+W-1:FRAC_BITS];
    pair_xy <= (W+1)'(prod_x) + (W+1)'(prod_y);
    pair_zo <= (W+1)'(prod_z) + (W+1)'(offset);
    res <= sum[W-1:0];
    ovf <= (sum[W+1:W-1] != 3'b000) && (sum[W+1:W-1] != 3'b111);
  end

endmodule

[rtl/fpvt_checker.sv]
module fpvt_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input fpvt_pkg::vertex_t  vertex,
  input logic               done,
  input fpvt_pkg::result_t  result
);

  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4))
    |-> (done == $past(start && !busy, 4)))
    else $error("result strobe does not match a request four cycles earlier");

  a_final_passes: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4) && done)
    |-> (result.final_result == $past(vertex.final_vertex, 4)))
    else $error("final marker does not follow its request");

  a_no_done_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  a_busy_only_in_reset: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy outside reset");

endmodule

bind fixed_point_vertex_transform_unit fpvt_checker u_fpvt_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .vertex(vertex),
  .done(done),
  .result(result)
);

[tb/tb_fixed_point_vertex_transform_unit.sv]
module tb_fixed_point_vertex_transform_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fpvt_pkg::*;

  localparam int FRAC = 16;
  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 7;
  localparam int SEGMENTS_PER_PACE = 2;
  localparam int ITEMS_PER_SEGMENT = 100;
  localparam int DRAIN_LIMIT = 1000;
  localparam int REPORT_LIMIT = 10;
  localparam int WATCHDOG_NS = 2_000_000;

  localparam int OFF_X_WORD = 9;
  localparam int OFF_Y_WORD = 10;
  localparam int OFF_Z_WORD = 11;

  localparam logic [WORD_W-1:0] W_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] W_ONE = 32'h0001_0000;
  localparam logic [WORD_W-1:0] W_NEG_ONE = 32'hFFFF_0000;
  localparam logic [WORD_W-1:0] W_LSB_NEG = 32'hFFFF_FFFF;

  localparam int unsigned COEF_SPAN = 32'h0004_0000;
  localparam int unsigned COORD_SPAN = 32'h0400_0000;

  localparam cfg_idx_t REG_NONE_LO = cfg_idx_t'(NUM_REGS);
  localparam cfg_idx_t REG_NONE_HI = cfg_idx_t'(NUM_REGS + 1);

  typedef enum logic {ROW_VERTEX, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    cfg_idx_t         index;
    logic [CFG_W-1:0] data;
    vertex_t          v;
    bit               typed;
    result_t          want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  vertex_t          req_vertex = '0;
  logic             done;
  result_t          rsp_result;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic             want_typed = 1'b0;
  result_t          typed_result = '0;

  logic [CFG_W-1:0] mirror_regs [NUM_REGS];
  result_t          awaited_results [$];
  stim_row_t        dir_rows [$];
  int unsigned      pace_pct = 0;

  int n_requests = 0;
  int n_results = 0;
  int n_mismatch = 0;
  int n_writes = 0;
  int n_ignored = 0;
  int n_overflow = 0;
  int n_final = 0;

  fixed_point_vertex_transform_unit #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .vertex(req_vertex),
    .done(done),
    .result(rsp_result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic signed [WORD_W-1:0] mirror_word(int k);
    logic [CFG_W-1:0] r;
    r = mirror_regs[k / 2];
    return (k % 2) ? r[CFG_W-1:WORD_W] : r[WORD_W-1:0];
  endfunction

  function automatic logic signed [WORD_W-1:0] scaled_product(
    logic signed [WORD_W-1:0] a, logic signed [WORD_W-1:0] b);
    logic signed [2*WORD_W-1:0] p;
    p = a * b;
    p = p >>> FRAC;
    return p[WORD_W-1:0];
  endfunction

  function automatic logic signed [2*WORD_W-1:0] axis_sum(vertex_t v, int c0, int ow);
    return scaled_product(v.in_x, mirror_word(c0))
         + scaled_product(v.in_y, mirror_word(c0 + 3))
         + scaled_product(v.in_z, mirror_word(c0 + 6))
         + mirror_word(ow);
  endfunction

  function automatic result_t transform_vertex(vertex_t v);
    logic signed [2*WORD_W-1:0] s [3];
    result_t r;
    s[0] = axis_sum(v, 0, OFF_X_WORD);
    s[1] = axis_sum(v, 1, OFF_Y_WORD);
    s[2] = axis_sum(v, 2, OFF_Z_WORD);
    r.out_x = s[0][WORD_W-1:0];
    r.out_y = s[1][WORD_W-1:0];
    r.out_z = s[2][WORD_W-1:0];
    r.overflow = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (s[i] != {{WORD_W{s[i][WORD_W-1]}}, s[i][WORD_W-1:0]}) begin
        r.overflow = 1'b1;
      end
    end
    r.final_result = v.final_vertex;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word(int unsigned span);
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 5))
      0, 1: w = $urandom();
      2: begin
        case ($urandom_range(0, 5))
          0: w = W_MIN;
          1: w = W_MAX;
          2: w = '0;
          3: w = W_LSB_NEG;
          4: w = W_ONE;
          default: w = W_NEG_ONE;
        endcase
      end
      3: begin
        if ($urandom_range(0, 1)) begin
          w = $urandom_range(0, 16'hFFFF);
        end else begin
          w = -$urandom_range(1, 16'hFFFF);
        end
      end
      default: w = $urandom_range(0, 2 * span) - span;
    endcase
    return w;
  endfunction

  function automatic void add_write(cfg_idx_t idx, logic [CFG_W-1:0] data);
    stim_row_t r;
    r = '{kind: ROW_WRITE, index: idx, data: data, v: '0, typed: 1'b0, want: '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_vertex(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
                                     logic [WORD_W-1:0] z, logic fin, bit typed,
                                     logic [WORD_W-1:0] ex, logic [WORD_W-1:0] ey,
                                     logic [WORD_W-1:0] ez, logic eovf);
    stim_row_t r;
    r.kind = ROW_VERTEX;
    r.index = '0;
    r.data = '0;
    r.v = '{x, y, z, fin};
    r.typed = typed;
    r.want = '{ex, ey, ez, eovf, fin};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_echo(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
                                   logic [WORD_W-1:0] z, logic fin);
    add_vertex(x, y, z, fin, 1'b1, x, y, z, 1'b0);
  endfunction

  function automatic void add_free(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
                                   logic [WORD_W-1:0] z, logic fin);
    add_vertex(x, y, z, fin, 1'b0, '0, '0, '0, 1'b0);
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst) begin
      mirror_regs = '{COEF_PAIR_A_RST, COEF_PAIR_B_RST, COEF_PAIR_C_RST,
                      COEF_PAIR_D_RST, COEF_LAST_SHIFT_X_RST, SHIFT_Y_Z_RST};
    end else begin
      if (done) begin
        n_results++;
        if (rsp_result.overflow) n_overflow++;
        if (rsp_result.final_result) n_final++;
        if (awaited_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= REPORT_LIMIT) begin
            $display("%0t: result with no request outstanding: x=%h y=%h z=%h",
                     $time, rsp_result.out_x, rsp_result.out_y, rsp_result.out_z);
          end
        end else begin
          want = awaited_results.pop_front();
          if (rsp_result.out_x !== want.out_x || rsp_result.out_y !== want.out_y ||
              rsp_result.out_z !== want.out_z || rsp_result.overflow !== want.overflow ||
              rsp_result.final_result !== want.final_result) begin
            n_mismatch++;
            if (n_mismatch <= REPORT_LIMIT) begin
              $display("%0t: result %0d differs: want x=%h y=%h z=%h ovf=%b last=%b",
                       $time, n_results, want.out_x, want.out_y, want.out_z,
                       want.overflow, want.final_result);
              $display("    got x=%h y=%h z=%h ovf=%b last=%b",
                       rsp_result.out_x, rsp_result.out_y, rsp_result.out_z,
                       rsp_result.overflow, rsp_result.final_result);
            end
          end
        end
      end
      if (start && !busy) begin
        n_requests++;
        awaited_results.push_back(want_typed ? typed_result : transform_vertex(req_vertex));
      end
      if (cfg_we) begin
        n_writes++;
        if (cfg_index < cfg_idx_t'(NUM_REGS)) begin
          mirror_regs[cfg_index] = cfg_data;
        end else begin
          n_ignored++;
        end
      end
    end
  end

  task automatic issue_vertex(vertex_t v, bit typed, result_t want);
    while ($urandom_range(0, 99) < pace_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req_vertex <= v;
    want_typed <= typed;
    typed_result <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    int spins;
    spins = 0;
    start <= 1'b0;
    while (awaited_results.size() != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic randomize_regs();
    cfg_idx_t idx;
    int unsigned lo_span;
    int unsigned hi_span;
    for (int r = 0; r < NUM_REGS; r++) begin
      idx = cfg_idx_t'(r);
      lo_span = (idx == REG_SHIFT_Y_Z) ? COORD_SPAN : COEF_SPAN;
      hi_span = (idx == REG_SHIFT_Y_Z || idx == REG_COEF_LAST_SHIFT_X) ?
                COORD_SPAN : COEF_SPAN;
      write_reg(idx, {pick_word(hi_span), pick_word(lo_span)});
    end
    if ($urandom_range(0, 1)) begin
      write_reg($urandom_range(0, 1) ? REG_NONE_LO : REG_NONE_HI,
                {32'($urandom()), 32'($urandom())});
    end
  endtask

  initial begin : stimulus
    int unsigned paces [3] = '{14, 72, 0};
    bit after_vertex;
    vertex_t v;

    add_echo('0, '0, '0, 1'b0);
    add_echo(W_MAX, W_MIN, W_NEG_ONE, 1'b1);
    add_echo(W_MIN, W_MAX, 32'h0000_0001, 1'b0);
    add_echo(W_LSB_NEG, W_ONE, 32'h5555_5555, 1'b1);
    add_echo(32'hAAAA_AAAA, 32'h0F0F_F0F0, 32'hF0F0_0F0F, 1'b0);
    add_write(REG_NONE_LO, '1);
    add_write(REG_NONE_HI, '1);
    add_echo(32'h1234_5678, 32'h8765_4321, W_MAX, 1'b1);
    add_write(REG_COEF_LAST_SHIFT_X, {W_MAX, W_ONE});
    add_vertex(32'h0000_0001, '0, '0, 1'b0, 1'b1, W_MIN, '0, '0, 1'b1);
    add_vertex(W_LSB_NEG, W_MAX, W_MIN, 1'b1, 1'b1, 32'h7FFF_FFFE, W_MAX, W_MIN, 1'b0);
    add_write(REG_SHIFT_Y_Z, {W_MIN, W_MAX});
    add_vertex('0, 32'h0000_0001, W_NEG_ONE, 1'b0, 1'b1, W_MAX, W_MIN, 32'h7FFF_0000, 1'b1);
    add_write(REG_COEF_PAIR_A, {W_MIN, W_MAX});
    add_write(REG_COEF_PAIR_B, {W_MAX, W_MIN});
    add_write(REG_COEF_PAIR_C, {W_MIN, W_MAX});
    add_write(REG_COEF_PAIR_D, '1);
    add_write(REG_COEF_LAST_SHIFT_X, {W_MIN, W_MIN});
    add_write(REG_SHIFT_Y_Z, {W_MAX, W_MIN});
    add_free(W_MAX, W_MAX, W_MAX, 1'b0);
    add_free(W_MIN, W_MIN, W_MIN, 1'b1);
    add_free(W_MIN, W_MAX, W_LSB_NEG, 1'b0);
    add_free(32'h0000_0001, W_LSB_NEG, W_ONE, 1'b0);
    add_free('0, '0, '0, 1'b1);
    add_write(REG_COEF_PAIR_A, {32'h0000_0000, 32'h0000_0001});
    add_write(REG_COEF_PAIR_B, '0);
    add_write(REG_COEF_PAIR_C, {32'h0000_0000, W_LSB_NEG});
    add_write(REG_COEF_PAIR_D, '0);
    add_write(REG_COEF_LAST_SHIFT_X, {32'h0000_0000, 32'h0000_8000});
    add_write(REG_SHIFT_Y_Z, '0);
    add_free(W_LSB_NEG, 32'h0000_0001, 32'h0000_0001, 1'b0);
    add_free(W_ONE, W_NEG_ONE, W_LSB_NEG, 1'b1);
    add_free(32'h0001_7FFF, 32'hFFFE_8001, 32'hFFFF_FFFD, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    pace_pct = paces[0];
    after_vertex = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        if (after_vertex) drain();
        write_reg(dir_rows[i].index, dir_rows[i].data);
        after_vertex = 1'b0;
      end else begin
        issue_vertex(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].want);
        after_vertex = 1'b1;
      end
    end
    drain();

    foreach (paces[p]) begin
      pace_pct = paces[p];
      for (int seg = 0; seg < SEGMENTS_PER_PACE; seg++) begin
        randomize_regs();
        for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
          v.in_x = pick_word(COORD_SPAN);
          v.in_y = pick_word(COORD_SPAN);
          v.in_z = pick_word(COORD_SPAN);
          v.final_vertex = 1'($urandom_range(0, 1));
          issue_vertex(v, 1'b0, '0);
        end
        drain();
      end
    end

    if (awaited_results.size() != 0) begin
      $display("%0d results never arrived", awaited_results.size());
      n_mismatch += awaited_results.size();
    end

    $display("Sent %0d vertices at three sender pacings; %0d register writes, %0d ignored.",
             n_requests, n_writes, n_ignored);
    $display("Checked %0d results: %0d flagged overflow, %0d marked last; %0d failures.",
             n_results, n_overflow, n_final, n_mismatch);
    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("Run did not finish in time.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
